// ----- rtl/dmm_pkg.sv -----
// Shared types, constants and reset values for the double matrix multiply core.
package dmm_pkg;

  // Default array limits handed to the top level
  localparam int DEF_MAX_ROWS  = 8;
  localparam int DEF_MAX_INNER = 8;

  // Largest column count of the product
  localparam int COL_LIMIT = 4096;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [1:0] REG_ROWS_M  = 2'd0;
  localparam logic [1:0] REG_INNER_K = 2'd1;
  localparam logic [1:0] REG_COLS_N  = 2'd2;

  // Register reset values
  localparam logic [3:0]  RST_ROWS_M  = 4'd8;
  localparam logic [3:0]  RST_INNER_K = 4'd8;
  localparam logic [12:0] RST_COLS_N  = 13'd8;

  // IEEE double constants
  localparam logic [63:0] POS_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

  // Multiply-add sequencer states
  typedef enum logic [2:0] {
    MAC_IDLE,
    MAC_MUL,
    MAC_ALIGN,
    MAC_SUM,
    MAC_NORM,
    MAC_DENORM,
    MAC_ROUND
  } mac_state_t;

  // Top-level control states
  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_READ,
    CTL_START,
    CTL_WAIT,
    CTL_EMIT
  } ctl_state_t;

  // Control shared by every accumulator cell of the chain
  typedef struct packed {
    logic        clear;
    logic        shift;
    logic [63:0] tail_value;
  } cell_ctrl_t;

endpackage

// ----- rtl/dmm_ifs.sv -----
// Valid/ready channel interfaces for input elements and product results.
interface dmm_elem_if;
  logic        valid;
  logic        ready;
  logic [63:0] element_bits;

  modport source (output valid, output element_bits, input ready);
  modport sink   (input valid, input element_bits, output ready);
endinterface

interface dmm_prod_if;
  logic        valid;
  logic        ready;
  logic [63:0] product_bits;
  logic [2:0]  row_index;
  logic [11:0] column_index;
  logic        last_of_column;
  logic        last_of_matrix;

  modport source (output valid, output product_bits, output row_index, output column_index,
                  output last_of_column, output last_of_matrix, input ready);
  modport sink   (input valid, input product_bits, input row_index, input column_index,
                  input last_of_column, input last_of_matrix, output ready);
endinterface

// ----- rtl/double_matrix_multiply_core.sv -----
// Top level: A store, accumulator cell chain, shared multiply-add and output stage.
//
//  channel   dir  handshake            payload
//  element   in   valid/ready          element_bits[63:0]
//  product   out  valid/ready          product_bits, row_index, column_index,
//                                      last_of_column, last_of_matrix
//  apb       in   psel/penable/pready  paddr, pwdata, prdata
//
// An A element is written straight into the A store. A B element takes m row passes;
// each pass is the A memory read plus the shared multiply-add sequencer (the first
// row skips the read state), with extra normalize steps on cancellation or
// subnormal results (16-bit shift steps).
// The K-th element of a column is followed by m emits, one per product row,
// each waiting while the output register is still held by the sink.
// Synchronous reset clears control and the column sums; A contents start undefined.
module double_matrix_multiply_core import dmm_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_INNER = DEF_MAX_INNER
) (
  input  logic                  clk,
  input  logic                  rst,
  dmm_elem_if.sink              element,
  dmm_prod_if.source            product,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ADEPTH  = MAX_ROWS * MAX_INNER;
  localparam int AADDR_W = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
  localparam int LCNT_W  = $clog2(ADEPTH + 1);
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int ICNT_W  = $clog2(MAX_INNER + 1);

  ctl_state_t state, state_next;

  logic [3:0]  rows_m;
  logic [3:0]  inner_k;
  logic [12:0] cols_n;

  logic              streaming;
  logic [LCNT_W-1:0] load_count;
  logic [ICNT_W-1:0] inner_count;
  logic [11:0]       column_count;
  logic [AADDR_W-1:0] ptr;
  logic [RCNT_W-1:0] row;
  logic [RCNT_W-1:0] emit_row;
  logic [63:0]       x_reg;

  logic        out_valid;
  logic [63:0] out_bits;
  logic [2:0]  out_row;
  logic [11:0] out_col;
  logic        out_loc;
  logic        out_lom;

  logic [RCNT_W-1:0] m_eff;
  logic [RCNT_W-1:0] m_last;
  logic [ICNT_W-1:0] k_eff;
  logic [ICNT_W-1:0] k_last;
  logic [12:0]       n_eff;
  logic [LCNT_W-1:0] mk;
  logic              last_col;

  logic [1:0] reg_idx;
  logic       cfg_wr;
  logic       cfg_restart;
  logic       in_acc;
  logic       out_free;

  logic [63:0] a_mem [ADEPTH];
  logic [63:0] a_rdata;

  logic        mac_start;
  logic        mac_busy;
  logic        mac_done;
  logic [63:0] mac_result;

  cell_ctrl_t  cell_ctrl;
  logic [63:0] cell_val [MAX_ROWS];

  // Saturate the size registers; a zero size counts as one
  always_comb begin
    if (rows_m == 4'd0) begin
      m_eff = RCNT_W'(1);
    end else if ({28'h0, rows_m} > 32'(MAX_ROWS)) begin
      m_eff = RCNT_W'(MAX_ROWS);
    end else begin
      m_eff = RCNT_W'(rows_m);
    end
    if (inner_k == 4'd0) begin
      k_eff = ICNT_W'(1);
    end else if ({28'h0, inner_k} > 32'(MAX_INNER)) begin
      k_eff = ICNT_W'(MAX_INNER);
    end else begin
      k_eff = ICNT_W'(inner_k);
    end
    if (cols_n == 13'd0) begin
      n_eff = 13'd1;
    end else if ({19'h0, cols_n} > 32'(COL_LIMIT)) begin
      n_eff = 13'(COL_LIMIT);
    end else begin
      n_eff = cols_n;
    end
  end

  assign m_last   = m_eff - RCNT_W'(1);
  assign k_last   = k_eff - ICNT_W'(1);
  assign mk       = LCNT_W'(m_eff * k_eff);
  assign last_col = ({1'b0, column_count} + 13'd1) >= n_eff;

  // Configuration port
  assign pready      = 1'b1;
  assign reg_idx     = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr      = psel && penable && pwrite;
  assign cfg_restart = cfg_wr && (reg_idx == REG_ROWS_M || reg_idx == REG_INNER_K
                                  || reg_idx == REG_COLS_N);

  always_comb begin
    unique case (reg_idx)
      REG_ROWS_M:  prdata = {28'h0, rows_m};
      REG_INNER_K: prdata = {28'h0, inner_k};
      REG_COLS_N:  prdata = {19'h0, cols_n};
      default:     prdata = '0;
    endcase
  end

  assign in_acc   = element.valid && element.ready;
  assign out_free = !out_valid || product.ready;

  // A store: write while loading, read the current pointer every cycle
  always_ff @(posedge clk) begin
    if (in_acc && !streaming) begin
      a_mem[load_count[AADDR_W-1:0]] <= element.element_bits;
    end
    a_rdata <= a_mem[ptr];
  end

  // Accumulator chain: cell 0 feeds the multiply-add, results enter at row m-1
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    logic [63:0] nb;
    if (i == MAX_ROWS - 1) begin : g_end
      assign nb = POS_ZERO;
    end else begin : g_mid
      assign nb = cell_val[i+1];
    end
    dmm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .tail      (RCNT_W'(i) == m_last),
      .from_next (nb),
      .value     (cell_val[i])
    );
  end

  dmm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .start    (mac_start),
    .x_bits   (x_reg),
    .a_bits   (a_rdata),
    .acc_bits (cell_val[0]),
    .busy     (mac_busy),
    .done     (mac_done),
    .result   (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CTL_IDLE: begin
        if (in_acc && streaming) begin
          state_next = CTL_START;
        end
      end
      CTL_READ:  state_next = CTL_START;
      CTL_START: state_next = CTL_WAIT;
      CTL_WAIT: begin
        if (mac_done) begin
          if (row != m_last) begin
            state_next = CTL_READ;
          end else if (inner_count == k_last) begin
            state_next = CTL_EMIT;
          end else begin
            state_next = CTL_IDLE;
          end
        end
      end
      CTL_EMIT: begin
        if (out_free && emit_row == m_last) begin
          state_next = CTL_IDLE;
        end
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  // Outputs of the control
  always_comb begin
    element.ready        = 1'b0;
    mac_start            = 1'b0;
    cell_ctrl.clear      = cfg_restart;
    cell_ctrl.shift      = 1'b0;
    cell_ctrl.tail_value = mac_result;
    unique case (state)
      CTL_IDLE:  element.ready = 1'b1;
      CTL_START: mac_start = 1'b1;
      CTL_WAIT:  cell_ctrl.shift = mac_done;
      CTL_EMIT: begin
        cell_ctrl.shift      = out_free;
        cell_ctrl.tail_value = POS_ZERO;
      end
      default: mac_start = 1'b0;
    endcase
  end

  // Counters, registers and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m       <= RST_ROWS_M;
      inner_k      <= RST_INNER_K;
      cols_n       <= RST_COLS_N;
      streaming    <= 1'b0;
      load_count   <= '0;
      inner_count  <= '0;
      column_count <= '0;
      ptr          <= '0;
      row          <= '0;
      emit_row     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Load a new transaction, or drop the held one once taken
      if (state == CTL_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (product.ready) begin
        out_valid <= 1'b0;
      end

      // Register write restarts the sequence
      if (cfg_restart) begin
        unique case (reg_idx)
          REG_ROWS_M:  rows_m  <= pwdata[3:0];
          REG_INNER_K: inner_k <= pwdata[3:0];
          default:     cols_n  <= pwdata[12:0];
        endcase
        streaming    <= 1'b0;
        load_count   <= '0;
        inner_count  <= '0;
        column_count <= '0;
        ptr          <= '0;
        row          <= '0;
        emit_row     <= '0;
      end

      // Count A loads, or start a B element
      if (in_acc) begin
        if (!streaming) begin
          if ((load_count + LCNT_W'(1)) >= mk) begin
            load_count   <= '0;
            streaming    <= 1'b1;
            inner_count  <= '0;
            column_count <= '0;
            ptr          <= '0;
          end else begin
            load_count <= load_count + LCNT_W'(1);
          end
        end else begin
          x_reg <= element.element_bits;
          row   <= '0;
        end
      end

      // Advance to the next row when the multiply-add finishes
      if (state == CTL_WAIT && mac_done) begin
        ptr <= ptr + AADDR_W'(1);
        row <= row + RCNT_W'(1);
        if (row == m_last && inner_count != k_last) begin
          inner_count <= inner_count + ICNT_W'(1);
        end
      end

      // Emit one product row per free output slot
      if (state == CTL_EMIT && out_free) begin
        out_bits  <= cell_val[0];
        out_row   <= 3'(emit_row);
        out_col   <= column_count;
        out_loc   <= emit_row == m_last;
        out_lom   <= (emit_row == m_last) && last_col;
        if (emit_row == m_last) begin
          emit_row    <= '0;
          inner_count <= '0;
          ptr         <= '0;
          if (last_col) begin
            column_count <= '0;
            streaming    <= 1'b0;
            load_count   <= '0;
          end else begin
            column_count <= column_count + 12'd1;
          end
        end else begin
          emit_row <= emit_row + RCNT_W'(1);
        end
      end
    end
  end

  assign product.valid          = out_valid;
  assign product.product_bits   = out_bits;
  assign product.row_index      = out_row;
  assign product.column_index   = out_col;
  assign product.last_of_column = out_loc;
  assign product.last_of_matrix = out_lom;

  // Input is only taken while the multiply-add is free
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    element.ready |-> !mac_busy)
    else $error("input taken while multiply-add busy");

  // A finished multiply-add is always awaited by the control
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == CTL_WAIT)
    else $error("multiply-add finished outside wait state");

  // Matrix end marks the end of a column too
  a_last_flags: assert property (@(posedge clk) disable iff (rst)
    (product.valid && product.last_of_matrix) |-> product.last_of_column)
    else $error("last_of_matrix without last_of_column");

  // Column count stays at zero while A loads
  a_load_col: assert property (@(posedge clk) disable iff (rst)
    !streaming |-> column_count == 12'd0)
    else $error("column count moved while loading A");

endmodule

// ----- rtl/dmm_cell.sv -----
// One accumulator cell of the rotating column-sum chain.
module dmm_cell import dmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  input  logic        tail,
  input  logic [63:0] from_next,
  output logic [63:0] value
);

  // Take the neighbor's sum on a shift; the tail cell takes the new value
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      value <= POS_ZERO;
    end else if (ctrl.shift) begin
      value <= tail ? ctrl.tail_value : from_next;
    end
  end

endmodule

// ----- rtl/dmm_mac.sv -----
// Sequential double-precision multiply then add, each rounded to nearest even.
module dmm_mac import dmm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x_bits,
  input  logic [63:0] a_bits,
  input  logic [63:0] acc_bits,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);

  mac_state_t state, state_next;

  logic [105:0]       w;
  logic [105:0]       w_small;
  logic signed [13:0] e;
  logic               sgn;
  logic               sub;
  logic               add_phase;
  logic [2:0]         cnt;
  logic [53:0]        pp;
  logic [1:0]         pp_sh;
  logic [52:0]        ma;
  logic [52:0]        mb;
  logic [63:0]        prod_bits;
  logic [63:0]        acc_hold;

  logic        xn, xi, xz, an, ai, az;
  logic        mul_special;
  logic [63:0] mul_special_value;
  logic        pn, pi, pz, qn, qi, qz;
  logic        add_special;
  logic [63:0] add_special_value;
  logic        p_big;
  logic [63:0] big;
  logic [63:0] sml;
  logic [10:0] be;
  logic [10:0] se;
  logic [10:0] dexp;
  logic [105:0] small_full;
  logic [105:0] small_shift;
  logic         small_sticky;
  logic [26:0]  op_a;
  logic [26:0]  op_b;
  logic [53:0]  mul_out;
  logic [105:0] pp_ext;
  logic [63:0]  rounded;

  function automatic logic is_nan(input logic [63:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] != 52'h0);
  endfunction

  function automatic logic is_inf(input logic [63:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] == 52'h0);
  endfunction

  function automatic logic is_zero(input logic [63:0] v);
    return v[62:0] == 63'h0;
  endfunction

  // Round a normalized 106-bit magnitude and pack it as a double
  function automatic logic [63:0] round_pack(input logic s, input logic [105:0] wv,
                                             input logic signed [13:0] ev);
    logic [52:0]        m;
    logic               g;
    logic               st;
    logic               inc;
    logic [53:0]        m2;
    logic [52:0]        mf;
    logic signed [13:0] ef;
    begin
      m   = wv[105:53];
      g   = wv[52];
      st  = |wv[51:0];
      inc = g & (st | m[0]);
      m2  = {1'b0, m} + {53'h0, inc};
      if (m2[53]) begin
        mf = m2[53:1];
        ef = ev + 14'sd1;
      end else begin
        mf = m2[52:0];
        ef = ev;
      end
      if (ef >= 14'sd2047) begin
        round_pack = {s, 11'h7FF, 52'h0};
      end else if (!mf[52]) begin
        round_pack = {s, 11'h0, mf[51:0]};
      end else begin
        round_pack = {s, ef[10:0], mf[51:0]};
      end
    end
  endfunction

  // Classify multiply operands
  always_comb begin
    xn = is_nan(x_bits);
    xi = is_inf(x_bits);
    xz = is_zero(x_bits);
    an = is_nan(a_bits);
    ai = is_inf(a_bits);
    az = is_zero(a_bits);
    mul_special = 1'b1;
    if (xn || an || (xi && az) || (ai && xz)) begin
      mul_special_value = CANON_NAN;
    end else if (xi || ai) begin
      mul_special_value = {x_bits[63] ^ a_bits[63], 11'h7FF, 52'h0};
    end else if (xz || az) begin
      mul_special_value = {x_bits[63] ^ a_bits[63], 63'h0};
    end else begin
      mul_special       = 1'b0;
      mul_special_value = POS_ZERO;
    end
  end

  // Classify add operands
  always_comb begin
    pn = is_nan(prod_bits);
    pi = is_inf(prod_bits);
    pz = is_zero(prod_bits);
    qn = is_nan(acc_hold);
    qi = is_inf(acc_hold);
    qz = is_zero(acc_hold);
    add_special = 1'b1;
    if (pn || qn || (pi && qi && (prod_bits[63] != acc_hold[63]))) begin
      add_special_value = CANON_NAN;
    end else if (pi) begin
      add_special_value = prod_bits;
    end else if (qi) begin
      add_special_value = acc_hold;
    end else if (pz && qz) begin
      add_special_value = {prod_bits[63] & acc_hold[63], 63'h0};
    end else if (pz) begin
      add_special_value = acc_hold;
    end else if (qz) begin
      add_special_value = prod_bits;
    end else begin
      add_special       = 1'b0;
      add_special_value = POS_ZERO;
    end
  end

  // Order add operands by magnitude and align the smaller one
  always_comb begin
    p_big        = prod_bits[62:0] >= acc_hold[62:0];
    big          = p_big ? prod_bits : acc_hold;
    sml          = p_big ? acc_hold : prod_bits;
    be           = (big[62:52] == 11'h0) ? 11'd1 : big[62:52];
    se           = (sml[62:52] == 11'h0) ? 11'd1 : sml[62:52];
    dexp         = be - se;
    small_full   = {1'b0, sml[62:52] != 11'h0, sml[51:0], 52'h0};
    small_shift  = small_full >> dexp;
    small_sticky = |(small_full & ~({106{1'b1}} << dexp));
  end

  // Select one partial product of the split mantissa multiply
  always_comb begin
    op_a = cnt[1] ? {1'b0, ma[52:27]} : ma[26:0];
    op_b = cnt[0] ? {1'b0, mb[52:27]} : mb[26:0];
  end

  assign mul_out = op_a * op_b;

  always_comb begin
    case (pp_sh)
      2'd1:    pp_ext = {25'h0, pp, 27'h0};
      2'd2:    pp_ext = {pp[51:0], 54'h0};
      default: pp_ext = {52'h0, pp};
    endcase
  end

  assign rounded = round_pack(sgn, w, e);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MAC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      MAC_IDLE: begin
        if (start) begin
          state_next = mul_special ? MAC_ALIGN : MAC_MUL;
        end
      end
      MAC_MUL: begin
        if (cnt == 3'd4) begin
          state_next = MAC_NORM;
        end
      end
      MAC_ALIGN: begin
        state_next = add_special ? MAC_IDLE : MAC_SUM;
      end
      MAC_SUM: begin
        state_next = MAC_NORM;
      end
      MAC_NORM: begin
        if (w == 106'h0) begin
          state_next = MAC_IDLE;
        end else if (!w[105]) begin
          state_next = MAC_NORM;
        end else if (e < 14'sd1 && e >= -14'sd110) begin
          state_next = MAC_DENORM;
        end else begin
          state_next = MAC_ROUND;
        end
      end
      MAC_DENORM: begin
        if (e >= 14'sd1) begin
          state_next = MAC_ROUND;
        end
      end
      MAC_ROUND: begin
        state_next = add_phase ? MAC_IDLE : MAC_ALIGN;
      end
      default: state_next = MAC_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy   = state != MAC_IDLE;
    done   = 1'b0;
    result = rounded;
    unique case (state)
      MAC_ALIGN: begin
        done   = add_special;
        result = add_special_value;
      end
      MAC_NORM: begin
        done   = w == 106'h0;
        result = POS_ZERO;
      end
      MAC_ROUND: begin
        done = add_phase;
      end
      default: done = 1'b0;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      MAC_IDLE: begin
        if (start) begin
          acc_hold  <= acc_bits;
          add_phase <= mul_special;
          prod_bits <= mul_special_value;
          cnt       <= 3'd0;
          w         <= 106'h0;
          sgn       <= x_bits[63] ^ a_bits[63];
          ma        <= {x_bits[62:52] != 11'h0, x_bits[51:0]};
          mb        <= {a_bits[62:52] != 11'h0, a_bits[51:0]};
          e         <= $signed({3'b0, (x_bits[62:52] == 11'h0) ? 11'd1 : x_bits[62:52]})
                     + $signed({3'b0, (a_bits[62:52] == 11'h0) ? 11'd1 : a_bits[62:52]})
                     - 14'sd1022;
        end
      end
      MAC_MUL: begin
        if (!cnt[2]) begin
          pp    <= mul_out;
          pp_sh <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
        end
        if (cnt != 3'd0) begin
          w <= w + pp_ext;
        end
        cnt <= cnt + 3'd1;
      end
      MAC_ALIGN: begin
        w         <= {1'b0, big[62:52] != 11'h0, big[51:0], 52'h0};
        w_small   <= small_shift | {105'h0, small_sticky};
        sub       <= big[63] ^ sml[63];
        sgn       <= big[63];
        e         <= $signed({3'b0, be}) + 14'sd1;
        add_phase <= 1'b1;
      end
      MAC_SUM: begin
        w <= sub ? (w - w_small) : (w + w_small);
      end
      MAC_NORM: begin
        if (w != 106'h0 && !w[105]) begin
          if (w[105:90] == 16'h0) begin
            w <= {w[89:0], 16'h0};
            e <= e - 14'sd16;
          end else begin
            w <= {w[104:0], 1'b0};
            e <= e - 14'sd1;
          end
        end else if (w[105] && e < -14'sd110) begin
          // Far below the subnormal range: only a sticky bit survives
          w <= {105'h0, 1'b1};
          e <= 14'sd1;
        end
      end
      MAC_DENORM: begin
        if (e <= -14'sd15) begin
          w <= {16'h0, w[105:17], w[16] | (|w[15:0])};
          e <= e + 14'sd16;
        end else if (e < 14'sd1) begin
          w <= {1'b0, w[105:2], w[1] | w[0]};
          e <= e + 14'sd1;
        end
      end
      MAC_ROUND: begin
        if (!add_phase) begin
          prod_bits <= rounded;
          add_phase <= 1'b1;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule
